// File: design/light_start_detect_calibrate_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the light start detect and calibrate core
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LIGHT_START_DETECT_CALIBRATE_CORE_MACROS_SVH
`define LIGHT_START_DETECT_CALIBRATE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define LSDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsdc same-cycle check failed");

// Check that cons holds in the cycle after ante
`define LSDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsdc next-cycle check failed");

`else

`define LSDC_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSDC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/lsdc_pkg.sv
// ----------------------------------------------------------------------------
// Light start detect and calibrate package
// Widths, reset values, register indexes and shared types of the core.
// ----------------------------------------------------------------------------
package lsdc_pkg;

   // Field and state widths
   localparam int NUM_SENSORS  = 3;
   localparam int SAMPLE_W     = 16;
   localparam int CLAMP_W      = 15;
   localparam int SUM3_W       = 17;
   localparam int MEAN_W       = 15;
   localparam int STAT_W       = 16;
   localparam int TIME_W       = 32;
   localparam int RATIO_W      = 16;
   localparam int DELTA_W      = 16;
   localparam int COUNT_W      = 32;
   localparam int DARK_SUM_W   = 48;
   localparam int PROD_W       = 32;
   localparam int PHASE_W      = 2;
   localparam int RATIO_FRAC_W = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DARK_MS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_BRIGHT_MS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_JUMP_RATIO_Q8    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_JUMP_DELTA       = 2'd3;

   localparam logic [TIME_W-1:0]  MIN_DARK_MS_RESET      = 32'd300;
   localparam logic [TIME_W-1:0]  SETTLE_BRIGHT_MS_RESET = 32'd80;
   localparam logic [RATIO_W-1:0] JUMP_RATIO_Q8_RESET    = 16'd256;
   localparam logic [DELTA_W-1:0] JUMP_DELTA_RESET       = 16'd40;

   // Calibration phases
   localparam logic [PHASE_W-1:0] PHASE_DARK   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_BRIGHT = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_DONE   = 2'd2;

   localparam logic [STAT_W-1:0]  MIN_RESET = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Serial dividers
   localparam int MEAN_DIVISOR = 3;
   localparam int DIV3_STEPS   = SUM3_W;
   localparam int DIV3_CNT_W   = $clog2(DIV3_STEPS);
   localparam int DIV_STEPS    = DARK_SUM_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   // Status of a serial unit towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// File: design/lsdc_div3.sv
// ----------------------------------------------------------------------------
// Serial divide by three
// Restoring division of the three-sample sum, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lsdc_div3 import lsdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM3_W-1:0]   dividend,
   output logic [MEAN_W-1:0]   quotient,
   output unit_status_type     status
);

   logic [SUM3_W-1:0]     dvd_ff, dvd_in;
   logic [1:0]            rem_ff, rem_in;
   logic [MEAN_W-1:0]     quo_ff, quo_in;
   logic [DIV3_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [2:0]            trial;
   logic                  fits;

   // Form one quotient bit per step
   always_comb begin
      trial  = {rem_ff, dvd_ff[SUM3_W-1]};
      fits   = (trial >= 3'(MEAN_DIVISOR));
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[SUM3_W-2:0], 1'b0};
         rem_in = fits ? 2'(trial - 3'(MEAN_DIVISOR)) : trial[1:0];
         quo_in = {quo_ff[MEAN_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV3_CNT_W'(DIV3_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control and datapath registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: design/lsdc_divider.sv
// ----------------------------------------------------------------------------
// Serial dark mean divider
// Restoring division of the dark sum by the dark count, one bit per cycle;
// keeps the low 16 quotient bits.
// ----------------------------------------------------------------------------
module lsdc_divider import lsdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DARK_SUM_W-1:0] dividend,
   input  logic [COUNT_W-1:0]    divisor,
   output logic [STAT_W-1:0]     quotient,
   output unit_status_type       status
);

   logic [DARK_SUM_W-1:0] dvd_ff, dvd_in;
   logic [COUNT_W-1:0]    dvs_ff, dvs_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [STAT_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_W:0]      trial;
   logic                  fits;

   // Shift in one dividend bit and try a subtract
   always_comb begin
      trial   = {rem_ff, dvd_ff[DARK_SUM_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DARK_SUM_W-2:0], 1'b0};
         rem_in = fits ? COUNT_W'(trial - {1'b0, dvs_ff}) : trial[COUNT_W-1:0];
         quo_in = {quo_ff[STAT_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control and datapath registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: design/light_start_detect_calibrate_core.sv
// ----------------------------------------------------------------------------
// Light start detect and calibrate core
// Tracks dark minima and a long-term dark mean over three light sensors,
// detects the jump to light and then collects per-sensor maxima.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  samples a..c, now_ms, restart
//  rsp       out        rsp_valid/rsp_stall  phase, finished, min, max, means
//  csr       in         csr_write            csr_index, csr_data
//
//  A restart item goes straight to the finish state; other items wait on the
//  17-step serial divide by three of the sample sum.
//  Once the dark window has run out, a dark phase item also runs the
//  48-step serial dark mean divider, then a multiply and a compare state.
//  Reset loads register defaults and clears the control and calibration state.
//  A result waiting on rsp_stall holds the next item in the sequencer only
//  after that item's own work is done.
// ----------------------------------------------------------------------------
`include "light_start_detect_calibrate_core_macros.svh"

module light_start_detect_calibrate_core import lsdc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // input items
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_a,
   input  logic signed [SAMPLE_W-1:0] req_sample_b,
   input  logic signed [SAMPLE_W-1:0] req_sample_c,
   input  logic [TIME_W-1:0]       req_now_ms,
   input  logic                    req_restart,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PHASE_W-1:0]      rsp_phase,
   output logic                    rsp_finished,
   output logic [STAT_W-1:0]       rsp_min_a,
   output logic [STAT_W-1:0]       rsp_min_b,
   output logic [STAT_W-1:0]       rsp_min_c,
   output logic [STAT_W-1:0]       rsp_max_a,
   output logic [STAT_W-1:0]       rsp_max_b,
   output logic [STAT_W-1:0]       rsp_max_c,
   output logic [STAT_W-1:0]       rsp_dark_mean,
   output logic [STAT_W-1:0]       rsp_current_mean,
   // configuration
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_UPDATE,
      ST_DIVIDE,
      ST_MUL,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [TIME_W-1:0]  min_dark_ff, settle_bright_ff;
   logic [RATIO_W-1:0] jump_ratio_ff;
   logic [DELTA_W-1:0] jump_delta_ff;

   // Item registers
   logic [CLAMP_W-1:0] samp_ff [NUM_SENSORS];
   logic [CLAMP_W-1:0] samp_in [NUM_SENSORS];
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // Calibration state
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [TIME_W-1:0]     start_ms_ff, start_ms_in;
   logic [STAT_W-1:0]     min_ff [NUM_SENSORS];
   logic [STAT_W-1:0]     min_in [NUM_SENSORS];
   logic [STAT_W-1:0]     max_ff [NUM_SENSORS];
   logic [STAT_W-1:0]     max_in [NUM_SENSORS];
   logic [COUNT_W-1:0]    dark_count_ff, dark_count_in;
   logic [DARK_SUM_W-1:0] dark_sum_ff, dark_sum_in;
   logic [STAT_W-1:0]     dark_mean_ff, dark_mean_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]    rsp_phase_ff, rsp_phase_in;
   logic                  rsp_finished_ff, rsp_finished_in;
   logic [STAT_W-1:0]     rsp_min_ff [NUM_SENSORS];
   logic [STAT_W-1:0]     rsp_min_in [NUM_SENSORS];
   logic [STAT_W-1:0]     rsp_max_ff [NUM_SENSORS];
   logic [STAT_W-1:0]     rsp_max_in [NUM_SENSORS];
   logic [STAT_W-1:0]     rsp_dark_mean_ff, rsp_dark_mean_in;
   logic [STAT_W-1:0]     rsp_cur_mean_ff, rsp_cur_mean_in;

   // Serial units
   logic                  div3_start;
   logic [SUM3_W-1:0]     sample_sum;
   logic [MEAN_W-1:0]     div3_quotient;
   unit_status_type       div3_status;
   logic                  div_start;
   logic [STAT_W-1:0]     div_quotient;
   unit_status_type       div_status;

   logic [CLAMP_W-1:0]    clamp [NUM_SENSORS];
   logic [SAMPLE_W-1:0]   raw [NUM_SENSORS];
   logic [TIME_W-1:0]     elapsed;
   logic [STAT_W-1:0]     delta_target;
   logic                  ratio_ok, delta_ok;
   logic                  accept, rsp_free;

   // Clamp negative samples to zero
   always_comb begin
      raw[0] = req_sample_a;
      raw[1] = req_sample_b;
      raw[2] = req_sample_c;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         clamp[i] = raw[i][SAMPLE_W-1] ? '0 : raw[i][CLAMP_W-1:0];
      end
   end

   assign sample_sum = SUM3_W'(clamp[0]) + SUM3_W'(clamp[1]) + SUM3_W'(clamp[2]);
   assign accept     = (state_ff == ST_IDLE) && req_valid;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign elapsed    = now_ff - start_ms_ff;
   assign ratio_ok   = (PROD_W'({mean_ff, RATIO_FRAC_W'(0)}) >= prod_ff);
   assign delta_target = dark_mean_ff + jump_delta_ff;
   assign delta_ok   = (STAT_W'(mean_ff) >= delta_target);

   // Sequence one item through mean, update, dark mean and jump test, or a restart, to the result
   always_comb begin
      state_in      = state_ff;
      samp_in       = samp_ff;
      now_in        = now_ff;
      mean_in       = mean_ff;
      prod_in       = prod_ff;
      phase_in      = phase_ff;
      start_ms_in   = start_ms_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      dark_count_in = dark_count_ff;
      dark_sum_in   = dark_sum_ff;
      dark_mean_in  = dark_mean_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_phase_in     = rsp_phase_ff;
      rsp_finished_in  = rsp_finished_ff;
      rsp_min_in       = rsp_min_ff;
      rsp_max_in       = rsp_max_ff;
      rsp_dark_mean_in = rsp_dark_mean_ff;
      rsp_cur_mean_in  = rsp_cur_mean_ff;
      div3_start    = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               samp_in = clamp;
               now_in  = req_now_ms;
               if (req_restart) begin
                  // clear all calibration state, use no sample
                  phase_in      = PHASE_DARK;
                  start_ms_in   = req_now_ms;
                  for (int i = 0; i < NUM_SENSORS; i++) begin
                     min_in[i] = MIN_RESET;
                     max_in[i] = '0;
                  end
                  dark_count_in = '0;
                  dark_sum_in   = '0;
                  dark_mean_in  = '0;
                  mean_in       = '0;
                  state_in      = ST_FINISH;
               end else begin
                  div3_start = 1'b1;
                  state_in   = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            if (div3_status.done) begin
               mean_in  = div3_quotient;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
            case (phase_ff)
               PHASE_DARK: begin
                  for (int i = 0; i < NUM_SENSORS; i++) begin
                     if (STAT_W'(samp_ff[i]) < min_ff[i]) begin
                        min_in[i] = STAT_W'(samp_ff[i]);
                     end
                  end
                  // saturate the count, freeze the sum with it
                  if (dark_count_ff != COUNT_MAX) begin
                     dark_count_in = dark_count_ff + 1'b1;
                     dark_sum_in   = dark_sum_ff + DARK_SUM_W'(mean_ff);
                  end
                  if (elapsed >= min_dark_ff) begin
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end
               end
               PHASE_BRIGHT: begin
                  for (int i = 0; i < NUM_SENSORS; i++) begin
                     if (STAT_W'(samp_ff[i]) > max_ff[i]) begin
                        max_in[i] = STAT_W'(samp_ff[i]);
                     end
                  end
                  if (elapsed >= settle_bright_ff) begin
                     phase_in    = PHASE_DONE;
                     start_ms_in = now_ff;
                  end
               end
               default: begin
                  // done: the state stays as it is
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               dark_mean_in = div_quotient;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(jump_ratio_ff) * PROD_W'(dark_mean_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // both jump tests pass: seed maxima and enter bright settle
            if (ratio_ok && delta_ok) begin
               for (int i = 0; i < NUM_SENSORS; i++) begin
                  if (STAT_W'(samp_ff[i]) > max_ff[i]) begin
                     max_in[i] = STAT_W'(samp_ff[i]);
                  end
               end
               phase_in    = PHASE_BRIGHT;
               start_ms_in = now_ff;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_phase_in     = phase_ff;
               rsp_finished_in  = (phase_ff >= PHASE_DONE);
               rsp_min_in       = min_ff;
               rsp_max_in       = max_ff;
               rsp_dark_mean_in = dark_mean_ff;
               rsp_cur_mean_in  = STAT_W'(mean_ff);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, calibration registers and the result register
   always_ff @(posedge clock) begin
      samp_ff          <= samp_in;
      now_ff           <= now_in;
      mean_ff          <= mean_in;
      prod_ff          <= prod_in;
      rsp_phase_ff     <= rsp_phase_in;
      rsp_finished_ff  <= rsp_finished_in;
      rsp_min_ff       <= rsp_min_in;
      rsp_max_ff       <= rsp_max_in;
      rsp_dark_mean_ff <= rsp_dark_mean_in;
      rsp_cur_mean_ff  <= rsp_cur_mean_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PHASE_DARK;
         start_ms_ff   <= '0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            min_ff[i] <= MIN_RESET;
            max_ff[i] <= '0;
         end
         dark_count_ff <= '0;
         dark_sum_ff   <= '0;
         dark_mean_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         start_ms_ff   <= start_ms_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         dark_count_ff <= dark_count_in;
         dark_sum_ff   <= dark_sum_in;
         dark_mean_ff  <= dark_mean_in;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dark_ff      <= MIN_DARK_MS_RESET;
         settle_bright_ff <= SETTLE_BRIGHT_MS_RESET;
         jump_ratio_ff    <= JUMP_RATIO_Q8_RESET;
         jump_delta_ff    <= JUMP_DELTA_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MIN_DARK_MS:      min_dark_ff      <= csr_data;
            CSR_SETTLE_BRIGHT_MS: settle_bright_ff <= csr_data;
            CSR_JUMP_RATIO_Q8:    jump_ratio_ff    <= csr_data[RATIO_W-1:0];
            CSR_JUMP_DELTA:       jump_delta_ff    <= csr_data[DELTA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lsdc_div3 u_div3 (
      .clock    (clock),
      .reset    (reset),
      .start    (div3_start),
      .dividend (sample_sum),
      .quotient (div3_quotient),
      .status   (div3_status)
   );

   lsdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dark_sum_in),
      .divisor  (dark_count_in),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Drive ports
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase        = rsp_phase_ff;
   assign rsp_finished     = rsp_finished_ff;
   assign rsp_min_a        = rsp_min_ff[0];
   assign rsp_min_b        = rsp_min_ff[1];
   assign rsp_min_c        = rsp_min_ff[2];
   assign rsp_max_a        = rsp_max_ff[0];
   assign rsp_max_b        = rsp_max_ff[1];
   assign rsp_max_c        = rsp_max_ff[2];
   assign rsp_dark_mean    = rsp_dark_mean_ff;
   assign rsp_current_mean = rsp_cur_mean_ff;

   // Checks
   `LSDC_ASSERT_SAME(a_units_idle, clock, reset, !req_stall, !div3_status.busy && !div_status.busy)
   `LSDC_ASSERT_SAME(a_div_done_in_divide, clock, reset, div_status.done, state_ff == ST_DIVIDE)
   `LSDC_ASSERT_SAME(a_phase_legal, clock, reset, 1'b1, phase_ff <= PHASE_DONE)
   `LSDC_ASSERT_SAME(a_dark_no_max, clock, reset, phase_ff == PHASE_DARK, max_ff[0] == '0 && max_ff[1] == '0 && max_ff[2] == '0)
   `LSDC_ASSERT_NEXT(a_restart_clears, clock, reset, accept && req_restart, phase_ff == PHASE_DARK && dark_count_ff == '0 && mean_ff == '0)

endmodule

// File: sim/light_start_detect_calibrate_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light start detect and calibrate core testbench
// Sends sample ticks through the core and predicts every result item with a
// behavioral model of the calibration. Runs directed edge cases, register
// extremes, output back-pressure, a sender pause and random calibration
// sessions under several register settings.
// ----------------------------------------------------------------------------
module light_start_detect_calibrate_core_tb;
   import lsdc_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 6;
   // longest item is a dark phase item once the dark window has run out
   localparam int SETTLE_CYCLES   = 80;
   // slowest item plus the longest receiver hold-off and sender gap, several times over
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int RANDOM_TICKS    = 1080;
   localparam int REGIMES         = 6;
   localparam int MAX_REPORTED    = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SAMPLE_W-1:0] b;
      logic signed [SAMPLE_W-1:0] c;
      logic [TIME_W-1:0]          now_ms;
      logic                       restart;
   } tick_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               finished;
      logic [STAT_W-1:0]  min_a;
      logic [STAT_W-1:0]  min_b;
      logic [STAT_W-1:0]  min_c;
      logic [STAT_W-1:0]  max_a;
      logic [STAT_W-1:0]  max_b;
      logic [STAT_W-1:0]  max_c;
      logic [STAT_W-1:0]  dark_mean;
      logic [STAT_W-1:0]  current_mean;
   } calib_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_a = '0;
   logic signed [SAMPLE_W-1:0] req_sample_b = '0;
   logic signed [SAMPLE_W-1:0] req_sample_c = '0;
   logic [TIME_W-1:0]          req_now_ms = '0;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [PHASE_W-1:0]         rsp_phase;
   logic                       rsp_finished;
   logic [STAT_W-1:0]          rsp_min_a;
   logic [STAT_W-1:0]          rsp_min_b;
   logic [STAT_W-1:0]          rsp_min_c;
   logic [STAT_W-1:0]          rsp_max_a;
   logic [STAT_W-1:0]          rsp_max_b;
   logic [STAT_W-1:0]          rsp_max_c;
   logic [STAT_W-1:0]          rsp_dark_mean;
   logic [STAT_W-1:0]          rsp_current_mean;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = CSR_MIN_DARK_MS;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // Predicted calibration state and register copies
   logic [PHASE_W-1:0]    cal_phase;
   logic [TIME_W-1:0]     cal_start_ms;
   logic [STAT_W-1:0]     cal_min [NUM_SENSORS];
   logic [STAT_W-1:0]     cal_max [NUM_SENSORS];
   logic [COUNT_W-1:0]    dark_count;
   logic [DARK_SUM_W-1:0] dark_sum;
   logic [STAT_W-1:0]     long_dark_mean;
   logic [TIME_W-1:0]     win_dark_ms;
   logic [TIME_W-1:0]     win_bright_ms;
   logic [RATIO_W-1:0]    ratio_thresh;
   logic [DELTA_W-1:0]    jump_delta;

   calib_report_type pending_reports [$];
   int               ticks_sent = 0;
   int               results_seen = 0;
   int               fault_count = 0;
   int               stuck_cycles = 0;
   int               hold_left = 0;
   bit               quiet = 1'b0;

   light_start_detect_calibrate_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_sample_c     (req_sample_c),
      .req_now_ms       (req_now_ms),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_phase        (rsp_phase),
      .rsp_finished     (rsp_finished),
      .rsp_min_a        (rsp_min_a),
      .rsp_min_b        (rsp_min_b),
      .rsp_min_c        (rsp_min_c),
      .rsp_max_a        (rsp_max_a),
      .rsp_max_b        (rsp_max_b),
      .rsp_max_c        (rsp_max_c),
      .rsp_dark_mean    (rsp_dark_mean),
      .rsp_current_mean (rsp_current_mean),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Calibration predictor
   // ------------------------------------------------------------------------
   function automatic void clear_calib(input logic [TIME_W-1:0] start_ms);
      cal_phase      = PHASE_DARK;
      cal_start_ms   = start_ms;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         cal_min[i] = MIN_RESET;
         cal_max[i] = '0;
      end
      dark_count     = '0;
      dark_sum       = '0;
      long_dark_mean = '0;
   endfunction

   function automatic logic [STAT_W-1:0] clamp_level(input logic signed [SAMPLE_W-1:0] raw);
      return raw[SAMPLE_W-1] ? '0 : raw;
   endfunction

   function automatic void raise_maxima(input logic [STAT_W-1:0] lvl [NUM_SENSORS]);
      for (int i = 0; i < NUM_SENSORS; i++)
         if (lvl[i] > cal_max[i]) cal_max[i] = lvl[i];
   endfunction

   function automatic calib_report_type predict_tick(input tick_type t);
      logic [STAT_W-1:0]     lvl [NUM_SENSORS];
      logic [SUM3_W-1:0]     sum3;
      logic [STAT_W-1:0]     tick_mean;
      logic [TIME_W-1:0]     elapsed;
      logic [DARK_SUM_W-1:0] quot;
      logic [STAT_W-1:0]     low;
      logic [STAT_W-1:0]     threshold;
      logic [63:0]           scaled_now;
      logic [63:0]           scaled_low;
      calib_report_type      r;
      lvl[0]    = clamp_level(t.a);
      lvl[1]    = clamp_level(t.b);
      lvl[2]    = clamp_level(t.c);
      tick_mean = '0;
      if (t.restart) begin
         clear_calib(t.now_ms);
      end else begin
         elapsed   = t.now_ms - cal_start_ms;
         sum3      = lvl[0] + lvl[1] + lvl[2];
         tick_mean = STAT_W'(sum3 / MEAN_DIVISOR);
         case (cal_phase)
            PHASE_DARK: begin
               for (int i = 0; i < NUM_SENSORS; i++)
                  if (lvl[i] < cal_min[i]) cal_min[i] = lvl[i];
               // hold count and sum once the count saturates
               if (dark_count != COUNT_MAX) begin
                  dark_count = dark_count + 1'b1;
                  dark_sum   = dark_sum + tick_mean;
               end
               if (elapsed >= win_dark_ms && dark_count != 0) begin
                  quot           = dark_sum / dark_count;
                  low            = quot[STAT_W-1:0];
                  long_dark_mean = low;
                  scaled_now     = 64'(tick_mean) << RATIO_FRAC_W;
                  scaled_low     = 64'(ratio_thresh) * 64'(low);
                  threshold      = low + jump_delta;
                  if (scaled_now >= scaled_low && tick_mean >= threshold) begin
                     raise_maxima(lvl);
                     cal_phase    = PHASE_BRIGHT;
                     cal_start_ms = t.now_ms;
                  end
               end
            end
            PHASE_BRIGHT: begin
               raise_maxima(lvl);
               if (elapsed >= win_bright_ms) begin
                  cal_phase    = PHASE_DONE;
                  cal_start_ms = t.now_ms;
               end
            end
            default: ;
         endcase
      end
      r.phase        = cal_phase;
      r.finished     = (cal_phase >= PHASE_DONE);
      r.min_a        = cal_min[0];
      r.min_b        = cal_min[1];
      r.min_c        = cal_min[2];
      r.max_a        = cal_max[0];
      r.max_b        = cal_max[1];
      r.max_c        = cal_max[2];
      r.dark_mean    = long_dark_mean;
      r.current_mean = tick_mean;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTED) $display("ERROR result %0d: %s", results_seen, msg);
   endtask

   task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                              input logic [STAT_W-1:0] got);
      if (got !== want) note_fault($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   always @(posedge clock) begin : check_results
      calib_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            note_fault("result item with no tick waiting");
         end else begin
            want = pending_reports.pop_front();
            check_field("phase", STAT_W'(want.phase), STAT_W'(rsp_phase));
            check_field("finished", STAT_W'(want.finished), STAT_W'(rsp_finished));
            check_field("min_a", want.min_a, rsp_min_a);
            check_field("min_b", want.min_b, rsp_min_b);
            check_field("min_c", want.min_c, rsp_min_c);
            check_field("max_a", want.max_a, rsp_max_a);
            check_field("max_b", want.max_b, rsp_max_b);
            check_field("max_c", want.max_c, rsp_max_c);
            check_field("dark_mean", want.dark_mean, rsp_dark_mean);
            check_field("current_mean", want.current_mean, rsp_current_mean);
         end
         results_seen++;
      end
   end

   // Receiver: random stall, long hold-off on request, none while quiet
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
   end

   // Watchdog: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic tick_type mk_tick(input logic [TIME_W-1:0] now_ms, input int a,
                                        input int b, input int c, input bit rst);
      tick_type t;
      t.a       = SAMPLE_W'(a);
      t.b       = SAMPLE_W'(b);
      t.c       = SAMPLE_W'(c);
      t.now_ms  = now_ms;
      t.restart = rst;
      return t;
   endfunction

   // Sample around a light level, sometimes a fully random reading
   function automatic int level_sample(input int lvl, input int jit);
      int v;
      if ($urandom_range(99) < 8) return int'(signed'(SAMPLE_W'($urandom)));
      v = lvl + int'($urandom_range(2 * jit)) - jit;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic send_tick(input tick_type t);
      int gap;
      gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(30, 1) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_sample_a <= t.a;
      req_sample_b <= t.b;
      req_sample_c <= t.c;
      req_now_ms   <= t.now_ms;
      req_restart  <= t.restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_reports.push_back(predict_tick(t));
      ticks_sent++;
   endtask

   // Drop valid, wait until every predicted result has been taken, then let the core settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [TIME_W-1:0] dark_ms, input logic [TIME_W-1:0] bright_ms,
                            input logic [RATIO_W-1:0] ratio, input logic [DELTA_W-1:0] delta);
      wait_idle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MIN_DARK_MS;
      csr_data  <= dark_ms;
      @(negedge clock);
      csr_index <= CSR_SETTLE_BRIGHT_MS;
      csr_data  <= bright_ms;
      @(negedge clock);
      csr_index <= CSR_JUMP_RATIO_Q8;
      csr_data  <= CSR_DATA_W'(ratio);
      @(negedge clock);
      csr_index <= CSR_JUMP_DELTA;
      csr_data  <= CSR_DATA_W'(delta);
      @(negedge clock);
      csr_write <= 1'b0;
      win_dark_ms   = dark_ms;
      win_bright_ms = bright_ms;
      ratio_thresh  = ratio;
      jump_delta    = delta;
   endtask

   // One calibration: restart, dark tracking, jump to light, bright settle, done
   task automatic run_session();
      logic [TIME_W-1:0] now_ms;
      longint unsigned   acc;
      int                dark_lvl;
      int                bright_lvl;
      int                jit;
      int                dt;
      int                dt_max;
      int                n;
      bit                rst;
      now_ms = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(400) : $urandom;
      send_tick(mk_tick(now_ms, $urandom, $urandom, $urandom, 1'b1));
      dark_lvl = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(3000);
      jit      = $urandom_range(30);

      // dark tracking up to the end of the window, with an odd restart
      dt_max = int'(win_dark_ms / 8) + 2;
      acc    = 0;
      n      = 0;
      while (acc < win_dark_ms && n < 40) begin
         dt     = $urandom_range(dt_max, 1);
         now_ms = now_ms + dt;
         acc    = acc + dt;
         rst    = ($urandom_range(49) == 0);
         if (rst) acc = 0;
         send_tick(mk_tick(now_ms, level_sample(dark_lvl, jit), level_sample(dark_lvl, jit),
                           level_sample(dark_lvl, jit), rst));
         n++;
      end
      repeat ($urandom_range(3)) begin
         now_ms = now_ms + $urandom_range(5, 1);
         send_tick(mk_tick(now_ms, level_sample(dark_lvl, jit), level_sample(dark_lvl, jit),
                           level_sample(dark_lvl, jit), 1'b0));
      end

      // jump to light, now and then too faint to pass
      if ($urandom_range(4) == 0)
         bright_lvl = dark_lvl + int'($urandom_range(jump_delta));
      else
         bright_lvl = (dark_lvl * int'(ratio_thresh)) / 256 + int'(jump_delta)
                      + int'($urandom_range(2000, 50));
      dt_max = int'(win_bright_ms / 6) + 2;
      acc    = 0;
      n      = 0;
      now_ms = now_ms + $urandom_range(5, 1);
      send_tick(mk_tick(now_ms, level_sample(bright_lvl, 200), level_sample(bright_lvl, 200),
                        level_sample(bright_lvl, 200), 1'b0));
      while (acc < win_bright_ms && n < 30) begin
         dt     = $urandom_range(dt_max, 1);
         now_ms = now_ms + dt;
         acc    = acc + dt;
         send_tick(mk_tick(now_ms, level_sample(bright_lvl, 400), level_sample(bright_lvl, 400),
                           level_sample(bright_lvl, 400), 1'b0));
         n++;
      end

      // one to four ticks with random samples at the end of the session
      repeat ($urandom_range(4, 1)) begin
         now_ms = now_ms + $urandom_range(50, 1);
         send_tick(mk_tick(now_ms, $urandom, $urandom, $urandom, 1'b0));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Sample and time extremes, clamping, restart, window edges, time wrap
   task automatic test_directed_edges();
      send_tick(mk_tick(32'd0, 0, 0, 0, 1'b0));
      send_tick(mk_tick(32'd10, 32767, 32767, 32767, 1'b0));
      send_tick(mk_tick(32'd20, -32768, -1, -32768, 1'b0));
      send_tick(mk_tick(32'd30, 100, 200, 300, 1'b0));
      // restart ignores its samples
      send_tick(mk_tick(32'hFFFF_FFFF, -1, 32767, 0, 1'b1));
      send_tick(mk_tick(32'd40, 50, 60, 40, 1'b0));
      send_tick(mk_tick(32'd150, 55, 45, 50, 1'b0));
      send_tick(mk_tick(32'd250, 48, 52, -7, 1'b0));
      // window just reached, no jump
      send_tick(mk_tick(32'd299, 50, 50, 50, 1'b0));
      send_tick(mk_tick(32'd305, 2000, 2100, 1900, 1'b0));
      // bright: minima stay frozen
      send_tick(mk_tick(32'd320, 2500, 1800, -5, 1'b0));
      send_tick(mk_tick(32'd384, 2200, 2200, 2200, 1'b0));
      send_tick(mk_tick(32'd385, 10, 20, 30, 1'b0));
      // done: mean still reported, state frozen
      send_tick(mk_tick(32'd400, 32767, 32767, 32767, 1'b0));
      send_tick(mk_tick(32'd401, -1, -1, -1, 1'b0));
      // dark window across the time wrap
      send_tick(mk_tick(32'hFFFF_FF00, 0, 0, 0, 1'b1));
      send_tick(mk_tick(32'hFFFF_FFF0, 30, 30, 30, 1'b0));
      send_tick(mk_tick(32'h0000_0010, 30, 30, 30, 1'b0));
      send_tick(mk_tick(32'h0000_0030, 30, 30, 30, 1'b0));
      send_tick(mk_tick(32'h0000_0040, 200, 200, 200, 1'b0));
   endtask

   // Register extremes: all-ones windows with elapsed all ones, zero windows
   task automatic test_register_extremes();
      configure('1, '1, '1, '1);
      send_tick(mk_tick(32'd5, 0, 0, 0, 1'b1));
      send_tick(mk_tick(32'd1000, 3, 3, 3, 1'b0));
      send_tick(mk_tick(32'd4, 300, 300, 300, 1'b0));
      send_tick(mk_tick(32'd4, 32767, 32767, 32767, 1'b0));
      // delta threshold wraps below the dark mean
      configure('1, '1, '0, '1);
      send_tick(mk_tick(32'd5, 0, 0, 0, 1'b1));
      send_tick(mk_tick(32'd6, 1, 1, 1, 1'b0));
      send_tick(mk_tick(32'd4, 1, 1, 1, 1'b0));
      send_tick(mk_tick(32'd9, 500, 400, 300, 1'b0));
      send_tick(mk_tick(32'd3, 7, 7, 7, 1'b0));
      configure('0, '0, '0, '0);
      send_tick(mk_tick(32'd77, 0, 0, 0, 1'b1));
      send_tick(mk_tick(32'd77, 9, 9, 9, 1'b0));
      send_tick(mk_tick(32'd77, 1, 2, 3, 1'b0));
      send_tick(mk_tick(32'd78, 4, 5, 6, 1'b0));
   endtask

   // Receiver holds off while the sender keeps offering ticks
   task automatic test_output_backpressure();
      configure(32'd120, 32'd40, 16'd320, 16'd60);
      quiet     = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      run_session();
      quiet     = 1'b0;
   endtask

   // Sender pauses until every result is back, then resumes
   task automatic test_sender_pause();
      run_session();
      wait_idle();
      run_session();
   endtask

   // Random sessions under several register settings
   task automatic test_random_regimes();
      int                goal;
      logic [TIME_W-1:0] dark_ms;
      logic [TIME_W-1:0] bright_ms;
      logic [RATIO_W-1:0] ratio;
      logic [DELTA_W-1:0] delta;
      for (int r = 0; r < REGIMES; r++) begin
         dark_ms   = (r == 1) ? '0 : $urandom_range(400);
         bright_ms = (r == 1) ? '0 : $urandom_range(150);
         ratio     = (r == 4) ? '0 : (r == 5) ? '1 : RATIO_W'($urandom_range(1024, 128));
         delta     = (r == 3) ? '1 : DELTA_W'($urandom_range(600));
         configure(dark_ms, bright_ms, ratio, delta);
         // one regime runs with no idling on either side
         quiet = (r == 2);
         goal  = ticks_sent + RANDOM_TICKS / REGIMES;
         while (ticks_sent < goal) run_session();
      end
      quiet = 1'b0;
   endtask

   initial begin
      win_dark_ms   = MIN_DARK_MS_RESET;
      win_bright_ms = SETTLE_BRIGHT_MS_RESET;
      ratio_thresh  = JUMP_RATIO_Q8_RESET;
      jump_delta    = JUMP_DELTA_RESET;
      clear_calib('0);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_register_extremes();
      test_output_backpressure();
      test_sender_pause();
      test_random_regimes();

      wait_idle();
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/lsdc_pkg.sv
design/lsdc_div3.sv
design/lsdc_divider.sv
design/light_start_detect_calibrate_core.sv
sim/light_start_detect_calibrate_core_tb.sv
